FILE: hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Fixed field widths of the request and result ports
  localparam int HALF_W     = 16;
  localparam int HANDLE_W   = 2 * HALF_W;
  localparam int REQ_W      = 2;
  localparam int LIVE_CNT_W = 11;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF    = 1024;
  localparam int GEN_BITS_DEF = 16;

  // Answer to a create request when every slot is taken
  localparam logic [HANDLE_W-1:0] INVALID_HANDLE = '1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // latch the request and launch the memory reads
    logic commit;  // evaluate, write back and present the result
  } cmd_t;

endpackage

FILE: hw/rtl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: takes a request when idle, then commits it in the
// datapath from the EXEC state.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output gha_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive commands and the busy flag
  always_comb begin
    cmd.accept = start && (state == ST_IDLE);
    cmd.commit = (state == ST_EXEC);
    busy       = (state != ST_IDLE);
  end

endmodule

FILE: hw/rtl/gha_dp.sv
// ----------------------------------------------------------------------------
// gha_dp
// Allocator datapath: slot memory (alive mark and generation), LIFO free
// stack memory, fill and live counters, and the registered result.
// ----------------------------------------------------------------------------
module gha_dp #(
  parameter int SLOTS    = gha_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gha_pkg::cmd_t                  cmd,
  input  logic [gha_pkg::REQ_W-1:0]      req_type,
  input  logic [gha_pkg::HANDLE_W-1:0]   handle_in,
  output logic                           done,
  output logic [gha_pkg::HANDLE_W-1:0]   handle_out,
  output logic                           success,
  output logic [gha_pkg::LIVE_CNT_W-1:0] live_count
);

  localparam int HW  = gha_pkg::HALF_W;
  localparam int AW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int GW  = GEN_BITS;
  localparam int LW  = gha_pkg::LIVE_CNT_W;
  localparam int SMW = GW + 1;   // slot entry: {alive, generation}
  localparam int FSW = GW + AW;  // stack entry: {generation, index}

  // Fill and live counters
  logic [CW-1:0] fsd;
  logic [CW-1:0] fsd_next;
  logic [CW-1:0] ever_used;
  logic [CW-1:0] ever_used_next;
  logic [CW-1:0] alive_total;
  logic [CW-1:0] alive_next;

  // Latched request
  gha_pkg::req_t                req_q;
  logic [gha_pkg::HANDLE_W-1:0] handle_q;

  // Memory ports
  logic           sm_we;
  logic [AW-1:0]  sm_waddr;
  logic [SMW-1:0] sm_wdata;
  logic [SMW-1:0] sm_rdata;
  logic           fs_we;
  logic           fs_re;
  logic [AW-1:0]  fs_raddr;
  logic [FSW-1:0] fs_rdata;
  logic [CW-1:0]  fsd_m1;

  // Evaluation
  logic [HW-1:0] h_idx;
  logic [HW-1:0] h_gen;
  logic          rd_alive;
  logic [GW-1:0] rd_gen;
  logic [GW-1:0] gen_inc;
  logic [GW-1:0] pop_gen;
  logic [AW-1:0] pop_idx;
  logic          in_range;
  logic          live;
  logic [gha_pkg::HANDLE_W-1:0] hout;
  logic          ok;

  // Launch reads at accept: slot entry of the handle, top of the free stack
  assign fsd_m1   = fsd - CW'(1);
  assign fs_re    = cmd.accept && (fsd != '0);
  assign fs_raddr = fsd_m1[AW-1:0];

  gha_ram #(.WIDTH(SMW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (cmd.accept),
    .raddr (handle_in[AW-1:0]),
    .rdata (sm_rdata)
  );

  gha_ram #(.WIDTH(FSW), .DEPTH(SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fsd[AW-1:0]),
    .wdata ({gen_inc, h_idx[AW-1:0]}),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  // Hold the request for the commit cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q    <= gha_pkg::req_t'(req_type);
      handle_q <= handle_in;
    end
  end

  // Decode the handle and the read data
  assign h_idx    = handle_q[HW-1:0];
  assign h_gen    = handle_q[gha_pkg::HANDLE_W-1:HW];
  assign rd_alive = sm_rdata[SMW-1];
  assign rd_gen   = sm_rdata[GW-1:0];
  assign gen_inc  = rd_gen + GW'(1);
  assign pop_gen  = fs_rdata[FSW-1:AW];
  assign pop_idx  = fs_rdata[AW-1:0];
  assign in_range = h_idx < HW'(ever_used);
  assign live     = in_range && rd_alive && (HW'(rd_gen) == h_gen);

  // Evaluate the request and form the write-back
  always_comb begin
    fsd_next       = fsd;
    ever_used_next = ever_used;
    alive_next     = alive_total;
    sm_we          = 1'b0;
    sm_waddr       = h_idx[AW-1:0];
    sm_wdata       = {1'b0, gen_inc};
    fs_we          = 1'b0;
    hout           = handle_q;
    ok             = 1'b0;
    case (req_q)
      gha_pkg::REQ_CREATE: begin
        if (fsd != '0) begin
          // reuse the most recently freed slot
          fsd_next   = fsd_m1;
          alive_next = alive_total + CW'(1);
          sm_we      = cmd.commit;
          sm_waddr   = pop_idx;
          sm_wdata   = {1'b1, pop_gen};
          hout       = {HW'(pop_gen), HW'(pop_idx)};
          ok         = 1'b1;
        end else if (ever_used < CW'(SLOTS)) begin
          // take a fresh slot at generation zero
          ever_used_next = ever_used + CW'(1);
          alive_next     = alive_total + CW'(1);
          sm_we          = cmd.commit;
          sm_waddr       = ever_used[AW-1:0];
          sm_wdata       = {1'b1, {GW{1'b0}}};
          hout           = {{HW{1'b0}}, HW'(ever_used)};
          ok             = 1'b1;
        end else begin
          hout = gha_pkg::INVALID_HANDLE;
        end
      end
      gha_pkg::REQ_DESTROY: begin
        if (live) begin
          // retire the slot, bump its generation and push it
          sm_we      = cmd.commit;
          fs_we      = cmd.commit && (fsd < CW'(SLOTS));
          fsd_next   = (fsd < CW'(SLOTS)) ? fsd + CW'(1) : fsd;
          alive_next = alive_total - CW'(1);
          ok         = 1'b1;
        end
      end
      gha_pkg::REQ_CHECK: ok = live;
      default: ok = 1'b0;
    endcase
  end

  // Update counters on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      fsd         <= '0;
      ever_used   <= '0;
      alive_total <= '0;
    end else if (cmd.commit) begin
      fsd         <= fsd_next;
      ever_used   <= ever_used_next;
      alive_total <= alive_next;
    end
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      handle_out <= hout;
      success    <= ok;
      live_count <= LW'(alive_next);
    end
  end

endmodule

FILE: hw/rtl/generational_handle_allocator_top.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Slot allocator handing out generation-tagged handles, with create,
// destroy and liveness check requests.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  request   start, busy            req_type, handle_in
//  result    done (one-cycle strobe) handle_out, success, live_count
//
//  A request is taken when start is high and busy is low. The cycle of
//  acceptance reads the slot memory and the top of the free stack; the next
//  cycle (busy high) compares, writes back and registers the result, which
//  shows with done in the cycle after. Reset clears the counters, the state and
//  done only: slots at or above the fill count are never read as live, so the
//  memories need no clearing pass.
//  Results cannot be stalled; done is high for exactly one cycle per request.
// ----------------------------------------------------------------------------
module generational_handle_allocator_top #(
  parameter int SLOTS    = gha_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gha_pkg::GEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [gha_pkg::REQ_W-1:0]      req_type,
  input  logic [gha_pkg::HANDLE_W-1:0]   handle_in,
  output logic                           done,
  output logic [gha_pkg::HANDLE_W-1:0]   handle_out,
  output logic                           success,
  output logic [gha_pkg::LIVE_CNT_W-1:0] live_count
);

  gha_pkg::cmd_t cmd;

  gha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  gha_dp #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .handle_in  (handle_in),
    .done       (done),
    .handle_out (handle_out),
    .success    (success),
    .live_count (live_count)
  );

endmodule

FILE: hw/rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks of request sequencing and result bounds.
// ----------------------------------------------------------------------------
module gha_checker #(
  parameter int SLOTS = gha_pkg::SLOTS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [gha_pkg::LIVE_CNT_W-1:0] live_count
);

  // An accepted transaction occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Busy lasts one cycle and is followed by the result strobe
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("result strobe missing after busy cycle");

  // Every result comes from a committed transaction
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction");

  // Live count shown with a result never exceeds the slot total (checked below 2048 slots)
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ((SLOTS >= 2048) || (int'(live_count) <= SLOTS)))
    else $error("live count above slot total");

endmodule

bind generational_handle_allocator_top gha_checker #(.SLOTS(SLOTS)) u_gha_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .live_count (live_count)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the generational handle allocator. A shadow of the
// slot table, the free stack and the counters predicts every result. Directed
// requests cover the corner cases from a fresh table; random request mixes
// then run under varying sender gaps, loading and unloading the free stack.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HALF_W      = gha_pkg::HALF_W;
  localparam int HANDLE_W    = gha_pkg::HANDLE_W;
  localparam int REQ_W       = gha_pkg::REQ_W;
  localparam int LIVE_CNT_W  = gha_pkg::LIVE_CNT_W;
  localparam int N_SLOTS     = gha_pkg::SLOTS_DEF;
  localparam int IDX_W       = $clog2(N_SLOTS);
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    gha_pkg::req_t       kind;
    logic [HANDLE_W-1:0] handle;
  } request_t;

  typedef struct {
    logic [HANDLE_W-1:0]   handle;
    logic                  ok;
    logic [LIVE_CNT_W-1:0] live;
  } result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic [REQ_W-1:0]      req_type  = gha_pkg::REQ_NONE;
  logic [HANDLE_W-1:0]   handle_in = '0;
  logic                  busy;
  logic                  done;
  logic [HANDLE_W-1:0]   handle_out;
  logic                  success;
  logic [LIVE_CNT_W-1:0] live_count;

  // Shadow of the allocator state
  logic [HALF_W-1:0] slot_gen   [N_SLOTS];
  logic              slot_alive [N_SLOTS];
  logic [HALF_W-1:0] free_lifo  [N_SLOTS];
  int                free_depth  = 0;
  int                fill_count  = 0;
  int                alive_count = 0;

  request_t pending_requests [$];
  result_t  expected_results [$];
  request_t next_req;

  int idle_pct    = 0;
  int error_count = 0;
  int cycle_count = 0;
  int n_created   = 0;
  int n_full      = 0;
  int n_freed     = 0;
  int n_refused   = 0;
  int n_live      = 0;
  int n_dead      = 0;
  int n_noop      = 0;

  generational_handle_allocator_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .handle_in  (handle_in),
    .done       (done),
    .handle_out (handle_out),
    .success    (success),
    .live_count (live_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Liveness of a handle against the shadow table
  function automatic logic handle_is_live(input logic [HANDLE_W-1:0] h);
    logic [HALF_W-1:0] idx;
    idx = h[HALF_W-1:0];
    if (int'(idx) >= fill_count) return 1'b0;
    return slot_alive[idx[IDX_W-1:0]] &&
           (slot_gen[idx[IDX_W-1:0]] == h[HANDLE_W-1:HALF_W]);
  endfunction

  // Apply one accepted request to the shadow and queue its expected result
  task automatic predict_allocation(input gha_pkg::req_t kind,
                                    input logic [HANDLE_W-1:0] h);
    result_t           r;
    logic [HALF_W-1:0] idx;
    logic              got;
    r.handle = h;
    r.ok     = 1'b0;
    got      = 1'b1;
    idx      = '0;
    case (kind)
      gha_pkg::REQ_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          idx = free_lifo[free_depth];
        end else if (fill_count < N_SLOTS) begin
          idx = fill_count[HALF_W-1:0];
          fill_count++;
          slot_gen[idx[IDX_W-1:0]] = '0;
        end else begin
          got = 1'b0;
        end
        if (got) begin
          slot_alive[idx[IDX_W-1:0]] = 1'b1;
          alive_count++;
          r.handle = {slot_gen[idx[IDX_W-1:0]], idx};
          r.ok     = 1'b1;
          n_created++;
        end else begin
          r.handle = gha_pkg::INVALID_HANDLE;
          n_full++;
        end
      end
      gha_pkg::REQ_DESTROY: begin
        if (handle_is_live(h)) begin
          idx = h[HALF_W-1:0];
          slot_alive[idx[IDX_W-1:0]] = 1'b0;
          slot_gen[idx[IDX_W-1:0]]   = slot_gen[idx[IDX_W-1:0]] + 1'b1;
          free_lifo[free_depth] = idx;
          free_depth++;
          alive_count--;
          r.ok = 1'b1;
          n_freed++;
        end else begin
          n_refused++;
        end
      end
      gha_pkg::REQ_CHECK: begin
        r.ok = handle_is_live(h);
        if (r.ok) n_live++;
        else n_dead++;
      end
      gha_pkg::REQ_NONE: n_noop++;
      default: n_noop++;
    endcase
    r.live = alive_count[LIVE_CNT_W-1:0];
    expected_results.insert(expected_results.size(), r);
  endtask

  // Driver: hold each transaction until taken, insert random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_allocation(gha_pkg::req_t'(req_type), handle_in);
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_req  = pending_requests.pop_front();
          start     <= 1'b1;
          req_type  <= next_req.kind;
          handle_in <= next_req.handle;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding: handle_out %h", handle_out);
        error_count++;
      end else begin
        if (handle_out !== expected_results[0].handle) begin
          $error("handle_out: expected %h, got %h", expected_results[0].handle, handle_out);
          error_count++;
        end
        if (success !== expected_results[0].ok) begin
          $error("success: expected %0b, got %0b", expected_results[0].ok, success);
          error_count++;
        end
        if (live_count !== expected_results[0].live) begin
          $error("live_count: expected %0d, got %0d", expected_results[0].live, live_count);
          error_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic queue_request(input gha_pkg::req_t kind, input logic [HANDLE_W-1:0] h);
    request_t q;
    q.kind   = kind;
    q.handle = h;
    pending_requests.insert(pending_requests.size(), q);
  endtask

  // Wait until every queued transaction is taken and answered
  task automatic drain();
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Pick a random live handle from the shadow; fall back to a random word
  function automatic logic [HANDLE_W-1:0] pick_live_handle();
    int idx;
    if (alive_count == 0) return $urandom;
    do idx = $urandom_range(0, fill_count - 1);
    while (!slot_alive[idx]);
    return {slot_gen[idx], idx[HALF_W-1:0]};
  endfunction

  // Handle that is not live: wrong generation or index out of range
  function automatic logic [HANDLE_W-1:0] pick_stale_handle();
    int                idx;
    logic [HALF_W-1:0] g;
    if (fill_count == 0 || $urandom_range(2) == 0) begin
      idx = $urandom_range(fill_count, 16'hFFFF);
      return {16'($urandom), idx[HALF_W-1:0]};
    end
    idx = $urandom_range(0, fill_count - 1);
    g   = slot_gen[idx] - 16'($urandom_range(1, 3));
    return {g, idx[HALF_W-1:0]};
  endfunction

  // Random request mix in small batches so picks follow the shadow state
  task automatic random_requests(input int count);
    int left;
    int r;
    left = count;
    while (left > 0) begin
      for (int i = 0; i < 16 && left > 0; i++) begin
        r = $urandom_range(99);
        if (r < 35)      queue_request(gha_pkg::REQ_CREATE, $urandom);
        else if (r < 60) queue_request(gha_pkg::REQ_DESTROY, pick_live_handle());
        else if (r < 72) queue_request(gha_pkg::REQ_CHECK, pick_live_handle());
        else if (r < 80) queue_request(gha_pkg::REQ_DESTROY, pick_stale_handle());
        else if (r < 88) queue_request(gha_pkg::REQ_CHECK, pick_stale_handle());
        else if (r < 95) queue_request($urandom_range(1) ? gha_pkg::REQ_CHECK
                                                         : gha_pkg::REQ_DESTROY, $urandom);
        else             queue_request(gha_pkg::REQ_NONE, $urandom);
        left--;
      end
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_gen[i]   = '0;
      slot_alive[i] = 1'b0;
      free_lifo[i]  = '0;
    end

    // Hold reset, then release it
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 13;

    // Directed corner cases from a fresh table
    queue_request(gha_pkg::REQ_CREATE,  32'hFFFF_FFFF);
    queue_request(gha_pkg::REQ_CREATE,  32'h0000_0000);
    queue_request(gha_pkg::REQ_CHECK,   32'h0000_0000);
    queue_request(gha_pkg::REQ_CHECK,   32'h0001_0000);
    queue_request(gha_pkg::REQ_CHECK,   32'h0000_0005);
    queue_request(gha_pkg::REQ_CHECK,   32'hFFFF_FFFF);
    queue_request(gha_pkg::REQ_DESTROY, 32'h0001_0000);
    queue_request(gha_pkg::REQ_DESTROY, 32'h0000_0009);
    queue_request(gha_pkg::REQ_DESTROY, 32'h0000_0000);
    queue_request(gha_pkg::REQ_DESTROY, 32'h0000_0000);
    queue_request(gha_pkg::REQ_CHECK,   32'h0000_0000);
    queue_request(gha_pkg::REQ_DESTROY, 32'h0000_0001);
    queue_request(gha_pkg::REQ_CREATE,  32'h5555_5555);
    queue_request(gha_pkg::REQ_CREATE,  32'hAAAA_AAAA);
    queue_request(gha_pkg::REQ_CREATE,  32'h0000_0000);
    queue_request(gha_pkg::REQ_NONE,    32'hFFFF_FFFF);
    queue_request(gha_pkg::REQ_NONE,    32'h0000_0000);
    queue_request(gha_pkg::REQ_CHECK,   32'hFFFF_0000);
    queue_request(gha_pkg::REQ_DESTROY, 32'hFFFF_FFFF);
    queue_request(gha_pkg::REQ_CHECK,   32'h0001_0001);
    drain();

    random_requests(180);
    idle_pct = 86;
    random_requests(180);
    idle_pct = 0;
    random_requests(170);

    // Let any stray result show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_count++;
    end

    $display("Creates: %0d slots handed out, %0d refused as full",
             n_created, n_full);
    $display("Destroys: %0d freed, %0d refused; checks: %0d live, %0d not live; %0d unused codes",
             n_freed, n_refused, n_live, n_dead, n_noop);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
